// ===== rtl/subsequence_dtw_matcher_defines.svh =====
// Assertion macros for the subsequence matcher
`ifndef SUBSEQUENCE_DTW_MATCHER_DEFINES_SVH
`define SUBSEQUENCE_DTW_MATCHER_DEFINES_SVH

// same-cycle implication, idle during reset
`define SDTW_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define SDTW_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdtw_pkg.sv =====
package sdtw_pkg;

  localparam int MAX_QUERY = 64;
  localparam int POS_W     = 16;
  localparam int SAMPLE_W  = 16;
  localparam int COST_W    = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CNT_W     = $clog2(MAX_QUERY + 1);
  localparam int DIFF_W    = SAMPLE_W + 1;

  localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       vld;
    logic [CNT_W-1:0]           cnt;
    logic signed [SAMPLE_W-1:0] smp;
    logic [COST_W-1:0]          up_cost;
    logic [POS_W-1:0]           up_start;
    logic [COST_W-1:0]          dg_cost;
    logic [POS_W-1:0]           dg_start;
  } tok_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] best;
    logic [POS_W-1:0]  bstart;
    logic [POS_W-1:0]  bend;
    logic              done;
  } res_t;

endpackage

// ===== rtl/sdtw_cell.sv =====
module sdtw_cell import sdtw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       wr_en,
  input  logic signed [SAMPLE_W-1:0] wr_value,
  input  tok_t                       tok_in,
  output tok_t                       tok_out
);

  logic signed [SAMPLE_W-1:0] q_r;
  logic [COST_W-1:0]          cost_r, cost_nxt;
  logic [POS_W-1:0]           start_r, start_nxt;
  tok_t                       tok_r, tok_nxt;

  logic                       act;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          absd;
  logic [COST_W-1:0]          m_cost;
  logic [POS_W-1:0]           m_start;
  logic [COST_W:0]            sum;
  logic [COST_W-1:0]          new_cost;

  always_comb begin
    act  = tok_in.vld && (tok_in.cnt != '0);
    diff = $signed({q_r[SAMPLE_W-1], q_r}) - $signed({tok_in.smp[SAMPLE_W-1], tok_in.smp});
    absd = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    if (tok_in.up_cost <= cost_r) begin
      m_cost  = tok_in.up_cost;
      m_start = tok_in.up_start;
    end else begin
      m_cost  = cost_r;
      m_start = start_r;
    end
    if (tok_in.dg_cost < m_cost) begin
      m_cost  = tok_in.dg_cost;
      m_start = tok_in.dg_start;
    end

    sum      = {1'b0, m_cost} + (COST_W+1)'(absd);
    new_cost = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];

    cost_nxt  = cost_r;
    start_nxt = start_r;
    if (clr) begin
      cost_nxt  = COST_INF;
      start_nxt = '0;
    end else if (act) begin
      cost_nxt  = new_cost;
      start_nxt = m_start;
    end

    tok_nxt.vld      = act;
    tok_nxt.cnt      = tok_in.cnt - CNT_W'(1);
    tok_nxt.smp      = tok_in.smp;
    tok_nxt.up_cost  = new_cost;
    tok_nxt.up_start = m_start;
    tok_nxt.dg_cost  = cost_r;
    tok_nxt.dg_start = start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r    <= COST_INF;
      start_r   <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      cost_r    <= cost_nxt;
      start_r   <= start_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.cnt      <= tok_nxt.cnt;
    tok_r.smp      <= tok_nxt.smp;
    tok_r.up_cost  <= tok_nxt.up_cost;
    tok_r.up_start <= tok_nxt.up_start;
    tok_r.dg_cost  <= tok_nxt.dg_cost;
    tok_r.dg_start <= tok_nxt.dg_start;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r <= wr_value;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/subsequence_dtw_matcher.sv =====
// A sample word passes the inject register, the first rows cells and the output register
// (rows = query_length clamped to 1..64); the next sample word is taken once the wavefront of
// the previous one has ended. Load words are taken one per cycle while in_stall is low.
// Reset: synchronous, active low; clears the cost column and best cost to all ones, starts,
// best positions and position to zero, query_length to 1. Query elements hold no reset value.
`include "subsequence_dtw_matcher_defines.svh"

module subsequence_dtw_matcher import sdtw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [IDX_W-1:0]           in_index,
  input  logic signed [SAMPLE_W-1:0] in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COST_W-1:0]          out_column_cost,
  output logic [COST_W-1:0]          out_best_distance,
  output logic [POS_W-1:0]           out_best_start,
  output logic [POS_W-1:0]           out_best_end,
  output logic                       out_done_res,
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data
);

  logic [CFG_W-1:0]  qlen_r;
  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  cur_pos_r, cur_pos_nxt;
  logic              done_r;
  logic [COST_W-1:0] best_cost_r, best_cost_nxt;
  logic [POS_W-1:0]  best_begin_r, best_begin_nxt;
  logic [POS_W-1:0]  best_finish_r, best_finish_nxt;
  tok_t              inj_r, inj_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  res_t              out_r, out_nxt;
  res_t              skid_r, skid_nxt;

  logic              acc, smp_acc, load_acc, fresh;
  logic [CNT_W-1:0]  rows;
  logic [POS_W-1:0]  next_pos;
  logic              out_take;
  tok_t              tok [MAX_QUERY+1];
  logic [MAX_QUERY-1:0] fin_vec;
  logic              fin;
  logic [COST_W-1:0] fin_cost;
  logic [POS_W-1:0]  fin_start;
  logic              upd;
  res_t              fin_res;

  assign in_stall = busy_r || skid_vld_r;
  assign acc      = in_valid && !in_stall;
  assign smp_acc  = acc && (in_opcode == OP_SAMPLE);
  assign load_acc = acc && (in_opcode == OP_LOAD);
  assign fresh    = smp_acc && (pos_r == '0);

  always_comb begin
    if (qlen_r == '0) begin
      rows = CNT_W'(1);
    end else if (CNT_W'(qlen_r) > CNT_W'(MAX_QUERY)) begin
      rows = CNT_W'(MAX_QUERY);
    end else begin
      rows = CNT_W'(qlen_r);
    end
    next_pos = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  end

  always_comb begin
    inj_nxt.vld      = smp_acc;
    inj_nxt.cnt      = rows;
    inj_nxt.smp      = in_value;
    inj_nxt.up_cost  = '0;
    inj_nxt.up_start = next_pos;
    inj_nxt.dg_cost  = '0;
    inj_nxt.dg_start = next_pos;
  end

  assign tok[0] = inj_r;

  for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
    sdtw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (fresh),
      .wr_en    (load_acc && (in_index == IDX_W'(i))),
      .wr_value (in_value),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
    assign fin_vec[i] = tok[i+1].vld && (tok[i+1].cnt == '0);
  end

  always_comb begin
    fin       = |fin_vec;
    fin_cost  = '0;
    fin_start = '0;
    for (int i = 0; i < MAX_QUERY; i++) begin
      fin_cost  = fin_cost  | ({COST_W{fin_vec[i]}} & tok[i+1].up_cost);
      fin_start = fin_start | ({POS_W{fin_vec[i]}} & tok[i+1].up_start);
    end
    upd = fin && (fin_cost < best_cost_r);

    fin_res.cost   = fin_cost;
    fin_res.best   = upd ? fin_cost  : best_cost_r;
    fin_res.bstart = upd ? fin_start : best_begin_r;
    fin_res.bend   = upd ? cur_pos_r : best_finish_r;
    fin_res.done   = done_r;
  end

  always_comb begin
    busy_nxt        = busy_r;
    pos_nxt         = pos_r;
    cur_pos_nxt     = cur_pos_r;
    best_cost_nxt   = best_cost_r;
    best_begin_nxt  = best_begin_r;
    best_finish_nxt = best_finish_r;
    if (smp_acc) begin
      busy_nxt    = 1'b1;
      cur_pos_nxt = next_pos;
      pos_nxt     = in_last ? '0 : next_pos;
    end
    if (fresh) begin
      best_cost_nxt   = COST_INF;
      best_begin_nxt  = '0;
      best_finish_nxt = '0;
    end
    if (fin) begin
      busy_nxt = 1'b0;
    end
    if (upd) begin
      best_cost_nxt   = fin_cost;
      best_begin_nxt  = fin_start;
      best_finish_nxt = cur_pos_r;
    end
  end

  always_comb begin
    out_take     = out_vld_r && !out_stall;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_take) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (fin) begin
        out_vld_nxt = 1'b1;
        out_nxt     = fin_res;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (fin) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r        <= CFG_W'(1);
      busy_r        <= 1'b0;
      pos_r         <= '0;
      cur_pos_r     <= '0;
      best_cost_r   <= COST_INF;
      best_begin_r  <= '0;
      best_finish_r <= '0;
      inj_r.vld     <= 1'b0;
      out_vld_r     <= 1'b0;
      skid_vld_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        qlen_r <= cfg_wr_data;
      end
      busy_r        <= busy_nxt;
      pos_r         <= pos_nxt;
      cur_pos_r     <= cur_pos_nxt;
      best_cost_r   <= best_cost_nxt;
      best_begin_r  <= best_begin_nxt;
      best_finish_r <= best_finish_nxt;
      inj_r.vld     <= inj_nxt.vld;
      out_vld_r     <= out_vld_nxt;
      skid_vld_r    <= skid_vld_nxt;
    end
    inj_r.cnt      <= inj_nxt.cnt;
    inj_r.smp      <= inj_nxt.smp;
    inj_r.up_cost  <= inj_nxt.up_cost;
    inj_r.up_start <= inj_nxt.up_start;
    inj_r.dg_cost  <= inj_nxt.dg_cost;
    inj_r.dg_start <= inj_nxt.dg_start;
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (smp_acc) begin
      done_r <= in_last;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_column_cost   = out_r.cost;
  assign out_best_distance = out_r.best;
  assign out_best_start    = out_r.bstart;
  assign out_best_end      = out_r.bend;
  assign out_done_res      = out_r.done;

  `SDTW_ASSERT_NOW(a_one_fin, clk, rst_n, 1'b1, $onehot0(fin_vec), "more than one wavefront end")
  `SDTW_ASSERT_NOW(a_fin_busy, clk, rst_n, fin, busy_r, "wavefront end while idle")
  `SDTW_ASSERT_NOW(a_skid_out, clk, rst_n, skid_vld_r, out_vld_r, "skid word behind empty output")
  `SDTW_ASSERT_NEXT(a_inject, clk, rst_n, smp_acc, inj_r.vld && busy_r, "sample not injected")

endmodule

// ===== bench/subsequence_dtw_checker.sv =====
`timescale 1ns / 1ps

module subsequence_dtw_checker import sdtw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [IDX_W-1:0]           in_index,
  input  logic signed [SAMPLE_W-1:0] in_value,
  input  logic                       in_last,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [COST_W-1:0]          out_column_cost,
  input  logic [COST_W-1:0]          out_best_distance,
  input  logic [POS_W-1:0]           out_best_start,
  input  logic [POS_W-1:0]           out_best_end,
  input  logic                       out_done_res,
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  output int                         mismatches,
  output int                         outstanding
);

  logic signed [SAMPLE_W-1:0] query_mem [MAX_QUERY];
  logic [COST_W-1:0]          cost_col  [MAX_QUERY];
  logic [POS_W-1:0]           start_col [MAX_QUERY];
  logic [COST_W-1:0]          best_cost;
  logic [POS_W-1:0]           best_begin;
  logic [POS_W-1:0]           best_finish;
  logic [POS_W-1:0]           seq_pos;
  logic [CFG_W-1:0]           qlen;
  res_t                       match_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input logic [COST_W-1:0] got,
                                 input logic [COST_W-1:0] want);
    if (mismatches < 200)
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_match_state();
    int i;
    for (i = 0; i < MAX_QUERY; i++) begin
      cost_col[i]  = COST_INF;
      start_col[i] = '0;
    end
    best_cost   = COST_INF;
    best_begin  = '0;
    best_finish = '0;
  endtask

  task automatic advance_column(input logic signed [SAMPLE_W-1:0] smp, input logic fin);
    int                i;
    int                rows;
    longint            delta;
    longint            sum;
    logic [COST_W-1:0] up_c, dg_c, left_c, m_c;
    logic [POS_W-1:0]  up_s, dg_s, left_s, m_s;
    res_t              r;
    rows = (qlen == 0) ? 1 : ((qlen > MAX_QUERY) ? MAX_QUERY : int'(qlen));
    if (seq_pos == 0)
      clear_match_state();
    if (seq_pos != POS_MAX)
      seq_pos++;
    dg_c = '0;
    dg_s = seq_pos;
    up_c = '0;
    up_s = seq_pos;
    for (i = 0; i < rows; i++) begin
      delta = longint'(query_mem[i]) - longint'(smp);
      if (delta < 0)
        delta = -delta;
      left_c = cost_col[i];
      left_s = start_col[i];
      if (up_c <= left_c) begin
        m_c = up_c;
        m_s = up_s;
      end else begin
        m_c = left_c;
        m_s = left_s;
      end
      if (dg_c < m_c) begin
        m_c = dg_c;
        m_s = dg_s;
      end
      dg_c = left_c;
      dg_s = left_s;
      sum = longint'(m_c) + delta;
      cost_col[i]  = (sum >= longint'(COST_INF)) ? COST_INF : sum[COST_W-1:0];
      start_col[i] = m_s;
      up_c = cost_col[i];
      up_s = m_s;
    end
    if (up_c < best_cost) begin
      best_cost   = up_c;
      best_begin  = up_s;
      best_finish = seq_pos;
    end
    r.cost   = up_c;
    r.best   = best_cost;
    r.bstart = best_begin;
    r.bend   = best_finish;
    r.done   = fin;
    match_q.push_back(r);
    if (fin)
      seq_pos = '0;
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      clear_match_state();
      seq_pos = '0;
      qlen    = CFG_W'(1);
      match_q.delete();
    end else begin
      if (cfg_wr_en)
        qlen = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (match_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_column_cost, '0);
        end else begin
          want = match_q.pop_front();
          if (out_column_cost !== want.cost)
            report_mismatch("column_cost", out_column_cost, want.cost);
          if (out_best_distance !== want.best)
            report_mismatch("best_distance", out_best_distance, want.best);
          if (out_best_start !== want.bstart)
            report_mismatch("best_start", COST_W'(out_best_start), COST_W'(want.bstart));
          if (out_best_end !== want.bend)
            report_mismatch("best_end", COST_W'(out_best_end), COST_W'(want.bend));
          if (out_done_res !== want.done)
            report_mismatch("done_res", COST_W'(out_done_res), COST_W'(want.done));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD)
          query_mem[in_index] = in_value;
        else
          advance_column(in_value, in_last);
      end
    end
    outstanding <= match_q.size();
  end

endmodule

// ===== bench/subsequence_dtw_matcher_tb.sv =====
`timescale 1ns / 1ps

module subsequence_dtw_matcher_tb;
  import sdtw_pkg::*;

  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_opcode = OP_LOAD;
  logic [IDX_W-1:0]           in_index = '0;
  logic signed [SAMPLE_W-1:0] in_value = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [COST_W-1:0]          out_column_cost;
  logic [COST_W-1:0]          out_best_distance;
  logic [POS_W-1:0]           out_best_start;
  logic [POS_W-1:0]           out_best_end;
  logic                       out_done_res;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]           cfg_wr_data = '0;

  int                         mismatches;
  int                         outstanding;
  int                         idle_cycles = 0;
  int                         stall_run = 0;
  stall_mode_t                stall_mode = STALL_NONE;
  int                         burst_left = 0;
  int                         item_count = 0;
  int                         rows_now = 1;
  bit                         loaded [MAX_QUERY];
  logic [SAMPLE_W-1:0]        qvals  [MAX_QUERY];

  subsequence_dtw_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_index         (in_index),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_cost  (out_column_cost),
    .out_best_distance(out_best_distance),
    .out_best_start   (out_best_start),
    .out_best_end     (out_best_end),
    .out_done_res     (out_done_res),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  subsequence_dtw_checker match_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_index         (in_index),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_cost  (out_column_cost),
    .out_best_distance(out_best_distance),
    .out_best_start   (out_best_start),
    .out_best_end     (out_best_end),
    .out_done_res     (out_done_res),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run  <= $urandom_range(20, 300);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      default:     out_stall <= ($urandom_range(0, 15) < 13);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int rows_for(input logic [CFG_W-1:0] v);
    if (v == 0)
      return 1;
    if (v > MAX_QUERY)
      return MAX_QUERY;
    return int'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3, 4: return qvals[$urandom_range(0, rows_now - 1)] +
                      SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // count down the burst; when it ends, add a random gap, then pick the next burst length
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                              : $urandom_range(1, 20);
    end
  endtask

  task automatic put_word(input logic op, input logic [IDX_W-1:0] idx,
                          input logic [SAMPLE_W-1:0] val, input logic lst);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_index  <= idx;
    in_value  <= val;
    in_last   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) begin
      loaded[idx] = 1'b1;
      qvals[idx]  = val;
    end
    item_count++;
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_QUERY + 6) @(posedge clk);
  endtask

  // write the length while idle, then load any row it exposes
  task automatic set_length(input logic [CFG_W-1:0] v);
    int i;
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rows_now = rows_for(v);
    for (i = 0; i < rows_now; i++)
      if (!loaded[i])
        put_word(OP_LOAD, IDX_W'(i), SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [CFG_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(MAX_QUERY);
      1:       return CFG_W'($urandom_range(MAX_QUERY + 1, 127));
      2:       return '0;
      3:       return CFG_W'($urandom_range(9, MAX_QUERY - 1));
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int n;
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_word(OP_LOAD, '0, 16'h8000, 1'b0);
    put_word(OP_SAMPLE, '0, 16'h7FFF, 1'b0);
    put_word(OP_SAMPLE, '1, 16'h8000, 1'b0);
    put_word(OP_SAMPLE, '0, 16'h0000, 1'b1);
    put_word(OP_LOAD, '0, 16'h7FFF, 1'b1);
    put_word(OP_LOAD, '1, 16'h0000, 1'b0);
    put_word(OP_SAMPLE, '0, 16'h8000, 1'b1);
    put_word(OP_SAMPLE, '0, 16'h7FFF, 1'b0);
    put_word(OP_SAMPLE, '0, 16'h7FFF, 1'b1);

    set_length('1);
    put_word(OP_SAMPLE, '0, 16'h7FFF, 1'b0);
    put_word(OP_SAMPLE, '0, 16'h8000, 1'b0);
    put_word(OP_SAMPLE, '0, qvals[0], 1'b1);
    set_length(CFG_W'(MAX_QUERY));
    put_word(OP_SAMPLE, '0, qvals[1], 1'b0);
    put_word(OP_SAMPLE, '0, qvals[2], 1'b1);

    // change the length in the middle of a sequence
    set_length(CFG_W'(2));
    put_word(OP_SAMPLE, '0, qvals[0], 1'b0);
    put_word(OP_SAMPLE, '0, qvals[1], 1'b0);
    set_length(CFG_W'(5));
    put_word(OP_SAMPLE, '0, qvals[2], 1'b0);
    put_word(OP_SAMPLE, '0, 16'h8000, 1'b1);

    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      set_length(pick_length());
      n = $urandom_range(20, 90);
      repeat (n) begin
        k = $urandom_range(0, 99);
        if (k < 80)
          put_word(OP_SAMPLE, IDX_W'($urandom), pick_sample(), $urandom_range(0, 11) == 0);
        else if (k < 90)
          put_word(OP_LOAD, IDX_W'($urandom), SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
        else
          put_word(1'($urandom_range(0, 1)), IDX_W'($urandom), SAMPLE_W'($urandom),
                   1'($urandom_range(0, 1)));
        if ($urandom_range(0, 199) == 0)
          drain();
      end
      if ($urandom_range(0, 2) != 0)
        put_word(OP_SAMPLE, IDX_W'($urandom), pick_sample(), 1'b1);
    end

    drain();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sdtw_pkg.sv
rtl/sdtw_cell.sv
rtl/subsequence_dtw_matcher.sv
bench/subsequence_dtw_checker.sv
bench/subsequence_dtw_matcher_tb.sv
